// ===== hw/rtl/vpw_frame_transmitter_assert.svh =====
// Assertion macros used by the frame transmitter checker.
`ifndef VPW_FRAME_TRANSMITTER_ASSERT_SVH
`define VPW_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VPW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vpw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VPW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vpw assertion failed");

`endif

// ===== hw/rtl/vpw_pkg.sv =====
// Shared types, codes, constants and CRC function of the VPW frame transmitter.
package vpw_pkg;

    localparam int BUFFER_BYTES_DEF = 16;
    localparam int BYTE_W           = 8;
    localparam int S_TDATA_W        = 16;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 24;
    localparam int TICK_W           = 16;
    localparam int TIMEOUT_W        = 24;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h1D;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOF     = 3'd0,
        REG_EOF     = 3'd1,
        REG_LONG    = 3'd2,
        REG_SHORT   = 3'd3,
        REG_TIMEOUT = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_WAIT    = 3'd1,
        ST_SENDING = 3'd2,
        ST_DONE    = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_ARB     = 3'd5,
        ST_REJECT  = 3'd6
    } status_t;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_WAIT    = 8'b0000_0010,
        PH_SOF     = 8'b0000_0100,
        PH_BITS    = 8'b0000_1000,
        PH_EOF     = 8'b0001_0000,
        PH_DONE    = 8'b0010_0000,
        PH_TIMEOUT = 8'b0100_0000,
        PH_ARB     = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]    sof_ticks;
        logic [TICK_W-1:0]    eof_ticks;
        logic [TICK_W-1:0]    long_ticks;
        logic [TICK_W-1:0]    short_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] data_byte;
        logic              bus_level;
    } item_t;

    typedef struct packed {
        logic              tx_level;
        status_t           status;
        logic [BYTE_W-1:0] frame_crc;
    } result_t;

    // One byte of CRC-8, MSB first, polynomial 0x1D.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[7] ^ b[3'(7 - i)];
            r  = {r[6:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/vpw_ram.sv =====
// Generic single-port-write, registered-read RAM.
module vpw_ram
    import vpw_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = BUFFER_BYTES_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/vpw_cfg.sv =====
// Configuration register file for pulse timing and timeout.
module vpw_cfg
    import vpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SOF:     cfg_next.sof_ticks     = cfg_data[TICK_W-1:0];
                REG_EOF:     cfg_next.eof_ticks     = cfg_data[TICK_W-1:0];
                REG_LONG:    cfg_next.long_ticks    = cfg_data[TICK_W-1:0];
                REG_SHORT:   cfg_next.short_ticks   = cfg_data[TICK_W-1:0];
                REG_TIMEOUT: cfg_next.timeout_ticks = cfg_data[TIMEOUT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_ticks     <= 16'd200;
            cfg_reg.eof_ticks     <= 16'd200;
            cfg_reg.long_ticks    <= 16'd128;
            cfg_reg.short_ticks   <= 16'd64;
            cfg_reg.timeout_ticks <= 24'd100000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// ===== hw/rtl/vpw_core.sv =====
// Frame state machine, CRC and frame buffer: one item per step.
module vpw_core
    import vpw_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    phase_t               phase_reg, phase_next;
    logic [CW-1:0]        loaded_reg, loaded_next;
    logic [7:0]           crc_reg, crc_next;
    logic [CW-1:0]        byte_idx_reg, byte_idx_next;
    logic [2:0]           bit_idx_reg, bit_idx_next;
    logic [TICK_W-1:0]    pulse_reg, pulse_next;
    logic [TICK_W-1:0]    idle_reg, idle_next;
    logic [TIMEOUT_W-1:0] wait_reg, wait_next;
    logic                 drive_reg, drive_next;
    logic [7:0]           cur_byte_reg, cur_byte_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic [CW:0]          idx_inc;

    logic                 busy;
    logic                 reject;
    logic [7:0]           tx_byte;
    logic                 use_long;
    logic [TICK_W-1:0]    bit_ticks;
    logic [TICK_W-1:0]    pulse_inc;
    logic [TICK_W-1:0]    idle_inc;
    logic [CW-1:0]        load_base;
    logic [7:0]           crc_base;
    logic [2:0]           bit_dec;
    status_t              phase_status;

    vpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Prefetch the byte after the current one; while waiting or in SOF, prefetch byte zero.
    // Each byte spans at least eight steps, so the registered read is ready in time.
    assign idx_inc = {1'b0, byte_idx_reg} + (CW+1)'(1);
    assign rd_addr = (phase_reg == PH_BITS && idx_inc < (CW+1)'(BUFFER_BYTES))
                   ? idx_inc[AW-1:0] : '0;

    assign busy = (phase_reg == PH_WAIT) || (phase_reg == PH_SOF) ||
                  (phase_reg == PH_BITS) || (phase_reg == PH_EOF);

    // Past the loaded bytes the CRC byte goes out.
    assign tx_byte   = (byte_idx_reg < loaded_reg) ? cur_byte_reg : ~crc_reg;
    // Odd bit positions are passive: long for a one; active positions are short for a one.
    assign use_long  = (tx_byte[bit_idx_reg] == bit_idx_reg[0]);
    assign bit_ticks = use_long ? cfg.long_ticks : cfg.short_ticks;
    assign pulse_inc = pulse_reg + TICK_W'(1);
    assign idle_inc  = !item.bus_level ? '0 :
                       (&idle_reg) ? idle_reg : idle_reg + TICK_W'(1);
    assign bit_dec   = bit_idx_reg - 3'd1;

    // A finished frame is dropped by the next load.
    assign load_base = (phase_reg != PH_IDLE) ? '0 : loaded_reg;
    assign crc_base  = (phase_reg != PH_IDLE) ? CRC_INIT : crc_reg;
    assign wr_addr   = load_base[AW-1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        loaded_next   = loaded_reg;
        crc_next      = crc_reg;
        byte_idx_next = byte_idx_reg;
        bit_idx_next  = bit_idx_reg;
        pulse_next    = pulse_reg;
        idle_next     = idle_reg;
        wait_next     = wait_reg;
        drive_next    = drive_reg;
        cur_byte_next = cur_byte_reg;
        reject        = 1'b0;
        wr_en         = 1'b0;

        if (step)
        begin
            unique case (item.op)
                OP_LOAD:
                begin
                    if (busy || load_base >= CW'(BUFFER_BYTES))
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        phase_next  = PH_IDLE;
                        loaded_next = load_base + CW'(1);
                        crc_next    = crc8_update(crc_base, item.data_byte);
                    end
                end
                OP_START:
                begin
                    if (busy)
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_WAIT;
                        idle_next     = '0;
                        wait_next     = '0;
                        pulse_next    = '0;
                        byte_idx_next = '0;
                        bit_idx_next  = 3'd7;
                        drive_next    = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            // Idle check wins over timeout.
                            idle_next = idle_inc;
                            if (idle_inc >= cfg.eof_ticks)
                            begin
                                phase_next = PH_SOF;
                                drive_next = 1'b0;
                                pulse_next = '0;
                            end
                            else if (wait_reg >= cfg.timeout_ticks)
                            begin
                                phase_next = PH_TIMEOUT;
                                drive_next = 1'b1;
                            end
                            else
                            begin
                                wait_next = wait_reg + TIMEOUT_W'(1);
                            end
                        end
                        PH_SOF:
                        begin
                            pulse_next = pulse_inc;
                            if (pulse_inc >= cfg.sof_ticks)
                            begin
                                phase_next    = PH_BITS;
                                byte_idx_next = '0;
                                bit_idx_next  = 3'd7;
                                drive_next    = 1'b1;
                                pulse_next    = '0;
                                cur_byte_next = rd_data;
                            end
                        end
                        PH_BITS:
                        begin
                            if (drive_reg && !item.bus_level)
                            begin
                                phase_next = PH_ARB;
                                drive_next = 1'b1;
                            end
                            else
                            begin
                                pulse_next = pulse_inc;
                                if (pulse_inc >= bit_ticks)
                                begin
                                    pulse_next = '0;
                                    if (bit_idx_reg != 3'd0)
                                    begin
                                        bit_idx_next = bit_dec;
                                        drive_next   = bit_dec[0];
                                    end
                                    else if (byte_idx_reg < loaded_reg)
                                    begin
                                        byte_idx_next = byte_idx_reg + CW'(1);
                                        bit_idx_next  = 3'd7;
                                        drive_next    = 1'b1;
                                        cur_byte_next = rd_data;
                                    end
                                    else
                                    begin
                                        phase_next = PH_EOF;
                                        drive_next = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_EOF:
                        begin
                            if (!item.bus_level)
                            begin
                                phase_next = PH_ARB;
                            end
                            else
                            begin
                                pulse_next = pulse_inc;
                                if (pulse_inc >= cfg.eof_ticks)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    reject = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (phase_next)
            PH_IDLE:    phase_status = ST_IDLE;
            PH_WAIT:    phase_status = ST_WAIT;
            PH_SOF:     phase_status = ST_SENDING;
            PH_BITS:    phase_status = ST_SENDING;
            PH_EOF:     phase_status = ST_SENDING;
            PH_DONE:    phase_status = ST_DONE;
            PH_TIMEOUT: phase_status = ST_TIMEOUT;
            PH_ARB:     phase_status = ST_ARB;
            default:    phase_status = ST_IDLE;
        endcase
    end

    assign result.tx_level  = drive_next;
    assign result.status    = reject ? ST_REJECT : phase_status;
    assign result.frame_crc = ~crc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            loaded_reg   <= '0;
            crc_reg      <= CRC_INIT;
            byte_idx_reg <= '0;
            bit_idx_reg  <= 3'd7;
            pulse_reg    <= '0;
            idle_reg     <= '0;
            wait_reg     <= '0;
            drive_reg    <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            loaded_reg   <= loaded_next;
            crc_reg      <= crc_next;
            byte_idx_reg <= byte_idx_next;
            bit_idx_reg  <= bit_idx_next;
            pulse_reg    <= pulse_next;
            idle_reg     <= idle_next;
            wait_reg     <= wait_next;
            drive_reg    <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
    end

endmodule

// ===== hw/rtl/vpw_frame_transmitter.sv =====
// Top level of the VPW frame transmitter: input register, core step, result register.
// A transfer taken on s_axis passes the input register, then the result register, to m_axis;
// throughput is one item per cycle while m_axis takes results, set by the single-step core.
// The result register lets the next item enter while a result waits on m_axis.
// Reset (rst_n, async, active low) empties both registers, loads the timing defaults and
// returns the sender to idle with an empty buffer; buffer RAM contents are not cleared.
module vpw_frame_transmitter
    import vpw_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte, [8] bus_level, rest zero
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // [1:0] op
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] tx_level, [3:1] status, [11:4] frame_crc
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    cfg_t    cfg;
    logic    advance;

    // Step the core whenever an item is held and the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture on each input transfer, hold the result until it is taken.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.op        <= s_axis_tuser[1:0];
            item_reg.data_byte <= s_axis_tdata[7:0];
            item_reg.bus_level <= s_axis_tdata[8];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    vpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vpw_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.frame_crc, out_reg.status, out_reg.tx_level};

endmodule

// ===== hw/rtl/vpw_chk.sv =====
// Port-level checker for the VPW frame transmitter, bound to the top level.
`include "vpw_frame_transmitter_assert.svh"

module vpw_chk
    import vpw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds.
    `VPW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // With no result pending, the block takes input.
    `VPW_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // The line is driven low only while a frame is on the wire.
    `VPW_ASSERT_IMP(a_passive_outside_frame, clk, rst_n, m_axis_tvalid && m_axis_tdata[3:1] != ST_SENDING && m_axis_tdata[3:1] != ST_REJECT, m_axis_tdata[0])

endmodule

bind vpw_frame_transmitter vpw_chk u_vpw_chk (.*);
